[hdl/nsv_pkg.sv]
// Package for the sentence validator: codes, character constants, body tracking types
// and the per-character update functions used by the top level.
// No dependencies.
package nsv_pkg;

    localparam int MAX_BODY_LEN = 255;
    // Length counter holds MAX_BODY_LEN + 1 to flag an over-long body
    localparam int LEN_W = $clog2(MAX_BODY_LEN + 2);
    localparam int SAT_W = (LEN_W > 9) ? LEN_W : 9;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [31:0] NAME_PTNL = "PTNL";

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_DOLLAR   = 4'd1;
    localparam logic [3:0] ST_CK_BAD      = 4'd2;
    localparam logic [3:0] ST_CK_MISMATCH = 4'd3;
    localparam logic [3:0] ST_CK_MISSING  = 4'd4;
    localparam logic [3:0] ST_NO_NAME     = 4'd5;
    localparam logic [3:0] ST_EMPTY       = 4'd6;
    localparam logic [3:0] ST_BAD_NAME    = 4'd7;
    localparam logic [3:0] ST_SHORT_NAME  = 4'd8;
    localparam logic [3:0] ST_BAD_FIELD   = 4'd9;
    localparam logic [3:0] ST_TOO_LONG    = 4'd10;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] c1;
        logic [LEN_W-1:0] c2;
        logic [7:0]       xr;
        logic [3:0][7:0]  head;
        logic [7:0]       commas;
        logic             has_c1;
        logic             has_c2;
        logic             nonalpha01;
        logic             nonalpha_mid;
        logic             nonalnum;
        logic             nonalpha_c1c2;
        logic             badp1;
        logic             badp2;
    } t_body;

    typedef struct packed {
        logic       in_sentence;
        logic       star_seen;
        logic [7:0] hex_acc;
        logic [1:0] hex_flags;
        t_body      body;
        t_body      snap;
    } t_trk;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic       checksum_present;
        logic [7:0] field_count;
        logic [7:0] name_length;
        logic       talker_stripped;
    } t_verdict;

    function automatic logic is_alpha(logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic param_ok(logic [7:0] c);
        return is_alnum(c) || (c inside {8'h2B, 8'h2D, 8'h2E, CH_COMMA});
    endfunction

    // Bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (is_digit(c)) begin
            v = 5'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic logic [7:0] sat8(logic [SAT_W-1:0] v);
        return (v > SAT_W'(255)) ? 8'hFF : v[7:0];
    endfunction

    function automatic t_body body_add(t_body b, logic [7:0] c);
        t_body r;
        logic [LEN_W-1:0] p;
        r = b;
        p = b.len;
        if (b.len <= LEN_W'(MAX_BODY_LEN)) begin
            r.len = b.len + LEN_W'(1);
            if (r.len <= LEN_W'(MAX_BODY_LEN)) begin
                r.xr = b.xr ^ c;
                if (p < LEN_W'(4)) begin
                    r.head[p[1:0]] = c;
                end
                if (!b.has_c1) begin
                    if (c == CH_COMMA) begin
                        r.has_c1 = 1'b1;
                        r.c1     = p;
                    end else begin
                        if (!is_alnum(c)) r.nonalnum = 1'b1;
                        if (!is_alpha(c)) begin
                            if (p < LEN_W'(2)) r.nonalpha01 = 1'b1;
                            else r.nonalpha_mid = 1'b1;
                        end
                    end
                end else begin
                    if (c == CH_COMMA && b.commas != 8'hFF) r.commas = b.commas + 8'd1;
                    if (!param_ok(c)) r.badp1 = 1'b1;
                    if (!b.has_c2) begin
                        if (c == CH_COMMA) begin
                            r.has_c2 = 1'b1;
                            r.c2     = p;
                        end else if (!is_alpha(c)) begin
                            r.nonalpha_c1c2 = 1'b1;
                        end
                    end else if (!param_ok(c)) begin
                        r.badp2 = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_trk commit_char(t_trk s, logic [7:0] c);
        t_trk r;
        logic [4:0] v;
        r = s;
        v = hex_value(c);
        if (c == CH_DOLLAR) begin
            r.in_sentence = 1'b1;
            r.body        = '0;
            r.star_seen   = 1'b0;
            r.hex_acc     = '0;
            r.hex_flags   = '0;
        end else if (s.in_sentence) begin
            if (c == CH_STAR) begin
                r.snap      = s.body;
                r.star_seen = 1'b1;
                r.hex_acc   = '0;
                r.hex_flags = '0;
            end else if (s.star_seen) begin
                if (v[4]) begin
                    r.hex_flags[0] = 1'b1;
                end else begin
                    r.hex_acc      = {s.hex_acc[3:0], v[3:0]};
                    r.hex_flags[1] = 1'b1;
                end
            end
            r.body = body_add(s.body, c);
        end
        return r;
    endfunction

endpackage

[hdl/nsv_if.sv]
// Stream interfaces for the sentence validator: raw text beats in, verdict beats out.
// No dependencies.
interface nsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface nsv_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic       checksum_present;
    logic [7:0] field_count;
    logic [7:0] name_length;
    logic       talker_stripped;

    modport source (output valid, status, computed_checksum, received_checksum,
                    checksum_present, field_count, name_length, talker_stripped,
                    input ready);
    modport sink (input valid, status, computed_checksum, received_checksum,
                  checksum_present, field_count, name_length, talker_stripped,
                  output ready);
endinterface

[hdl/nsv_eval.sv]
// Verdict logic: turns the captured state of a closed line into status and fields.
// Depends on nsv_pkg.
module nsv_eval
    import nsv_pkg::*;
(
    input  t_trk     i_trk,
    input  logic     i_allow_missing,
    output t_verdict o_verdict
);

    t_body            b;
    logic             done;
    logic             talker;
    logic             valid_name;
    logic             badp;
    logic [SAT_W-1:0] name_len;
    logic [SAT_W-1:0] count;

    always_comb begin
        o_verdict  = '0;
        done       = 1'b0;
        talker     = 1'b0;
        valid_name = 1'b1;
        badp       = 1'b0;
        name_len   = '0;
        count      = '0;
        b          = i_trk.star_seen ? i_trk.snap : i_trk.body;

        if (!i_trk.in_sentence) begin
            o_verdict.status = ST_NO_DOLLAR;
            done = 1'b1;
        end else if (i_trk.body.len > LEN_W'(MAX_BODY_LEN)) begin
            o_verdict.status = ST_TOO_LONG;
            done = 1'b1;
        end else begin
            o_verdict.computed_checksum = b.xr;
            o_verdict.checksum_present  = i_trk.star_seen;
            if (i_trk.star_seen) begin
                o_verdict.received_checksum = i_trk.hex_acc;
                if (i_trk.hex_flags[0]) begin
                    o_verdict.status = ST_CK_BAD;
                    done = 1'b1;
                end else if (i_trk.hex_acc != b.xr) begin
                    o_verdict.status = ST_CK_MISMATCH;
                    done = 1'b1;
                end
            end else if (!i_allow_missing) begin
                o_verdict.status = ST_CK_MISSING;
                done = 1'b1;
            end
        end

        talker = b.head[0] == 8'h47 &&
                 (b.head[1] inside {8'h41, 8'h42, 8'h49, 8'h4C, 8'h4E, 8'h50, 8'h51});

        if (!done) begin
            if (!b.has_c1) begin
                if (b.len == '0) begin
                    o_verdict.status = ST_EMPTY;
                    done = 1'b1;
                end else if (b.nonalnum) begin
                    o_verdict.status = ST_BAD_NAME;
                    done = 1'b1;
                end else if (b.len < LEN_W'(4)) begin
                    o_verdict.status = ST_SHORT_NAME;
                    done = 1'b1;
                end else begin
                    name_len = SAT_W'(b.len) - SAT_W'(2);
                    count    = SAT_W'(1);
                end
            end else if (b.c1 == '0) begin
                o_verdict.status = ST_NO_NAME;
                done = 1'b1;
            end else if (b.c1 < LEN_W'(4)) begin
                o_verdict.status = ST_SHORT_NAME;
                done = 1'b1;
            end else if (talker) begin
                name_len   = SAT_W'(b.c1) - SAT_W'(2);
                valid_name = !b.nonalpha_mid;
                badp       = b.badp1;
                count      = SAT_W'(b.commas) + SAT_W'(1);
            end else if (b.c1 == LEN_W'(4) &&
                         {b.head[0], b.head[1], b.head[2], b.head[3]} == NAME_PTNL) begin
                valid_name = !b.nonalpha_c1c2;
                if (b.has_c2) begin
                    name_len = SAT_W'(b.c2);
                    badp     = b.badp2;
                    count    = SAT_W'(b.commas);
                end else begin
                    name_len = SAT_W'(b.len);
                    count    = SAT_W'(1);
                end
            end else begin
                name_len   = SAT_W'(b.c1);
                valid_name = !b.nonalpha01 && !b.nonalpha_mid;
                badp       = b.badp1;
                count      = SAT_W'(b.commas) + SAT_W'(1);
            end
        end

        if (!done) begin
            if (!valid_name) begin
                o_verdict.status = ST_BAD_NAME;
            end else begin
                o_verdict.status          = badp ? ST_BAD_FIELD : ST_OK;
                o_verdict.field_count     = sat8(count);
                o_verdict.name_length     = sat8(name_len);
                o_verdict.talker_stripped = talker;
            end
        end
    end

endmodule

[hdl/nmea_sentence_validator.sv]
// Sentence validator top level: line tracking, verdict capture and output register.
// Depends on nsv_pkg, nsv_if (nsv_in_if, nsv_out_if) and nsv_eval.
//
// i_in carries one text byte per beat with an end_of_text flag; o_out carries one
// verdict per non-empty line. Both use valid/ready; a beat moves when both are high.
// i_cfg_wr_en with i_cfg_wr_data writes allow_missing_checksum (reset value 1);
// write it only while no line is in flight.
// Throughput: one byte per cycle while o_out is not stalled. Each byte updates
// the line state register; a held carriage return and the new byte are folded
// in together. The closed line is captured into the event register, then its
// verdict is formed into the output register.
// Reset (i_rst_n low, synchronous) clears the line state, both pipeline stages and
// sets allow_missing_checksum. While o_out is stalled the pipeline holds and i_in
// ready drops only if the output register is full.
module nmea_sentence_validator
    import nsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    nsv_in_if.sink        i_in,
    nsv_out_if.source     o_out,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data
);

    logic     r_allow;
    t_trk     r_trk, n_trk;
    logic     r_pend, n_pend;
    logic     r_nonempty, n_nonempty;
    t_trk     r_ev;
    logic     r_ev_valid, n_ev_valid;
    t_verdict r_out;
    logic     r_out_valid;

    t_trk     w_upd;
    t_verdict w_verdict;
    logic     w_advance;
    logic     w_accept;
    logic     w_close;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = w_advance;
    assign w_accept   = i_in.valid && w_advance;

    // Fold a held carriage return in before any byte other than a line feed
    always_comb begin
        w_upd      = r_trk;
        n_pend     = r_pend;
        n_nonempty = r_nonempty;
        w_close    = 1'b0;
        n_trk      = r_trk;
        n_ev_valid = 1'b0;
        if (i_in.text_byte == CH_LF) begin
            w_close = 1'b1;
        end else begin
            n_nonempty = 1'b1;
            if (r_pend) begin
                w_upd = commit_char(w_upd, CH_CR);
            end
            n_pend = 1'b0;
            if (i_in.text_byte == CH_CR) begin
                n_pend = 1'b1;
            end else if (i_in.text_byte != CH_SPACE && i_in.text_byte != CH_TAB) begin
                w_upd = commit_char(w_upd, i_in.text_byte);
            end
            w_close = i_in.end_of_text;
        end
        if (w_accept) begin
            if (w_close) begin
                n_ev_valid = n_nonempty;
                n_trk      = '0;
                n_pend     = 1'b0;
                n_nonempty = 1'b0;
            end else begin
                n_trk = w_upd;
            end
        end else begin
            n_pend     = r_pend;
            n_nonempty = r_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow     <= 1'b1;
            r_trk       <= '0;
            r_pend      <= 1'b0;
            r_nonempty  <= 1'b0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_allow <= i_cfg_wr_data;
            end
            r_trk      <= n_trk;
            r_pend     <= n_pend;
            r_nonempty <= n_nonempty;
            if (w_advance) begin
                r_ev_valid  <= n_ev_valid;
                r_out_valid <= r_ev_valid;
            end
        end
    end

    // Capture the closed line and the finished verdict
    always_ff @(posedge i_clk) begin
        if (w_accept && w_close) begin
            r_ev <= w_upd;
        end
        if (w_advance && r_ev_valid) begin
            r_out <= w_verdict;
        end
    end

    nsv_eval u_eval (
        .i_trk           (r_ev),
        .i_allow_missing (r_allow),
        .o_verdict       (w_verdict)
    );

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out.status;
    assign o_out.computed_checksum = r_out.computed_checksum;
    assign o_out.received_checksum = r_out.received_checksum;
    assign o_out.checksum_present  = r_out.checksum_present;
    assign o_out.field_count       = r_out.field_count;
    assign o_out.name_length       = r_out.name_length;
    assign o_out.talker_stripped   = r_out.talker_stripped;

endmodule
